>>> sv/vaos_pkg.sv
// vaos_pkg: shared types and constants of the voice allocator
// used by voice_allocator_oldest_steal_core, no dependencies
`default_nettype none

package vaos_pkg;

    localparam int VOICES = 16;
    localparam int IDX_W  = $clog2(VOICES);
    localparam int CNT_W  = $clog2(VOICES + 1);
    localparam int MASK_W = 16;
    localparam int SLOT_W = 4;
    localparam int NOTE_W = 7;
    localparam int CHAN_W = 4;
    localparam int ORD_W  = 32;
    localparam int FUNC_W = 3;

    localparam logic [FUNC_W-1:0] FN_NOTE_ON  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_NOTE_OFF = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FINISHED = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ALL_OFF  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR    = 3'd4;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [CHAN_W-1:0] chan;
        logic [ORD_W-1:0]  order;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

>>> sv/vaos_ram.sv
// vaos_ram: generic single-write, single-read ram with registered read data
// standalone, no package dependency
`default_nettype none

module vaos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> sv/voice_allocator_oldest_steal_core.sv
// voice_allocator_oldest_steal_core: polyphonic voice allocator, oldest-note stealing
// depends on vaos_pkg and vaos_ram (note, channel and start order per voice)
//
// channel | signals                                        | direction
// request | start, busy, i_func, i_note_number,             | in
//         | i_midi_channel, i_finished_slot                |
// result  | o_result_strobe, o_assigned_slot, o_was_stolen, | out
//         | o_released_mask, o_active_mask                 |
//
// note on with a free voice, finished, all off, clear, other codes: result in the cycle after start
// note on with all voices busy and note off: scan of the voice ram, one entry a
// cycle through its registered read port, then a finish step that registers the result
// busy is high during the scan and the finish step; results are single-cycle strobes, no backpressure
// synchronous active-low reset frees all voices and zeroes the start counter
`default_nettype none

module voice_allocator_oldest_steal_core
    import vaos_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [FUNC_W-1:0] i_func,
    input  wire logic [NOTE_W-1:0] i_note_number,
    input  wire logic [CHAN_W-1:0] i_midi_channel,
    input  wire logic [SLOT_W-1:0] i_finished_slot,
    output logic                   o_result_strobe,
    output logic [SLOT_W-1:0]      o_assigned_slot,
    output logic                   o_was_stolen,
    output logic [MASK_W-1:0]      o_released_mask,
    output logic [MASK_W-1:0]      o_active_mask
);

    t_state              r_state, n_state;
    logic [VOICES-1:0]   r_active, n_active;
    logic [ORD_W-1:0]    r_ctr, n_ctr;
    logic [NOTE_W-1:0]   r_note, n_note;
    logic [CHAN_W-1:0]   r_chan, n_chan;
    logic                r_is_on, n_is_on;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]    r_best_idx, n_best_idx;
    logic [ORD_W-1:0]    r_best_ord, n_best_ord;
    logic [VOICES-1:0]   r_released, n_released;
    logic                r_strobe, n_strobe;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic                r_stolen, n_stolen;
    logic [MASK_W-1:0]   r_rel_out, n_rel_out;
    logic [MASK_W-1:0]   r_act_out, n_act_out;

    logic                accept;
    logic                free_any;
    logic [IDX_W-1:0]    free_idx;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    t_entry              ram_wdata;
    t_entry              ram_rdata;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign free_any = !(&r_active);

    // lowest free voice
    always_comb begin
        free_idx = '0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    vaos_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (VOICES)
    ) u_voice_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if ((i_func == FN_NOTE_ON && !free_any) || i_func == FN_NOTE_OFF) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_rd_vld && r_rd_idx == IDX_W'(VOICES - 1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_active   = r_active;
        n_ctr      = r_ctr;
        n_note     = r_note;
        n_chan     = r_chan;
        n_is_on    = r_is_on;
        n_cnt      = r_cnt;
        n_rd_vld   = 1'b0;
        n_rd_idx   = r_rd_idx;
        n_best_idx = r_best_idx;
        n_best_ord = r_best_ord;
        n_released = r_released;
        n_strobe   = 1'b0;
        n_slot     = '0;
        n_stolen   = 1'b0;
        n_rel_out  = '0;
        ram_we     = 1'b0;
        ram_waddr  = free_idx;
        ram_wdata  = '{note: i_note_number, chan: i_midi_channel, order: r_ctr};

        unique case (r_state)
            ST_IDLE: begin
                n_cnt      = '0;
                n_released = '0;
                if (accept) begin
                    n_note  = i_note_number;
                    n_chan  = i_midi_channel;
                    n_is_on = (i_func == FN_NOTE_ON);
                    case (i_func)
                        FN_NOTE_ON: begin
                            if (free_any) begin
                                ram_we             = 1'b1;
                                n_active[free_idx] = 1'b1;
                                n_ctr              = r_ctr + 1'b1;
                                n_strobe           = 1'b1;
                                n_slot             = SLOT_W'(free_idx);
                            end
                        end
                        FN_NOTE_OFF: begin
                        end
                        FN_FINISHED: begin
                            if (int'(i_finished_slot) < VOICES) begin
                                n_active[i_finished_slot[IDX_W-1:0]] = 1'b0;
                            end
                            n_strobe = 1'b1;
                        end
                        FN_ALL_OFF: begin
                            n_rel_out = MASK_W'(r_active);
                            n_strobe  = 1'b1;
                        end
                        FN_CLEAR: begin
                            n_active = '0;
                            n_ctr    = '0;
                            n_strobe = 1'b1;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_cnt < CNT_W'(VOICES)) begin
                    n_cnt    = r_cnt + 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_cnt[IDX_W-1:0];
                end
                if (r_rd_vld) begin
                    if (r_is_on) begin
                        if (r_rd_idx == '0 || ram_rdata.order < r_best_ord) begin
                            n_best_idx = r_rd_idx;
                            n_best_ord = ram_rdata.order;
                        end
                    end else if (r_active[r_rd_idx] && ram_rdata.note == r_note
                                 && ram_rdata.chan == r_chan) begin
                        n_released[r_rd_idx] = 1'b1;
                    end
                end
            end
            ST_FINISH: begin
                n_strobe = 1'b1;
                if (r_is_on) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_best_idx;
                    ram_wdata = '{note: r_note, chan: r_chan, order: r_ctr};
                    n_ctr     = r_ctr + 1'b1;
                    n_slot    = SLOT_W'(r_best_idx);
                    n_stolen  = 1'b1;
                end else begin
                    n_rel_out = MASK_W'(r_released);
                end
            end
            default: begin
            end
        endcase

        n_act_out = MASK_W'(n_active);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= '0;
            r_ctr    <= '0;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_ctr    <= n_ctr;
            r_cnt    <= n_cnt;
            r_rd_vld <= n_rd_vld;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_note     <= n_note;
        r_chan     <= n_chan;
        r_is_on    <= n_is_on;
        r_rd_idx   <= n_rd_idx;
        r_best_idx <= n_best_idx;
        r_best_ord <= n_best_ord;
        r_released <= n_released;
        if (n_strobe) begin
            r_slot    <= n_slot;
            r_stolen  <= n_stolen;
            r_rel_out <= n_rel_out;
            r_act_out <= n_act_out;
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_assigned_slot = r_slot;
    assign o_was_stolen    = r_stolen;
    assign o_released_mask = r_rel_out;
    assign o_active_mask   = r_act_out;

    // a stolen voice means every voice was active
    a_steal_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_was_stolen) |-> (o_active_mask == MASK_W'({VOICES{1'b1}})))
        else $error("steal reported with a free voice");

    // released voices are always active ones
    a_rel_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> ((o_released_mask & ~o_active_mask) == '0))
        else $error("released voice not active");

    // the finish step only follows a completed scan
    a_finish_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |-> ($past(r_state) == ST_SCAN && $past(r_rd_vld)))
        else $error("finish without scan");

    // a result only follows an accepted request or the finish step
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result_strobe) |-> ($past(accept) || $past(r_state) == ST_FINISH))
        else $error("result without request");

endmodule

`default_nettype wire
